FILE: rtl/ctr_pkg.sv
// Package: operation codes, limits and the ring entry type of the call trace ring.
package ctr_pkg;

	localparam logic [2:0] OP_CALL   = 3'd0;
	localparam logic [2:0] OP_RETURN = 3'd1;
	localparam logic [2:0] OP_READ   = 3'd2;
	localparam logic [2:0] OP_RANGE  = 3'd3;
	localparam logic [2:0] OP_TAKE   = 3'd4;
	localparam logic [2:0] OP_CLEAR  = 3'd5;

	localparam logic [47:0] INDEX_MAX  = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] EXCESS_MAX = 16'hFFFF;
	localparam logic [10:0] CAP_RESET  = 11'd1024;

	typedef struct packed {
		logic [63:0]        t;
		logic [31:0]        func;
		logic signed [31:0] line;
		logic               is_ret;
	} ring_entry_t;

endpackage

FILE: rtl/ctr_if.sv
// Interfaces: input and result channels of the call trace ring.
interface ctr_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         operation;
	logic [31:0]        func_index;
	logic signed [31:0] line;
	logic [63:0]        time_ns;
	logic [47:0]        range_begin;
	logic [47:0]        range_end;

	modport source (output valid, operation, func_index, line, time_ns, range_begin,
		range_end, input ready);
	modport sink (input valid, operation, func_index, line, time_ns, range_begin,
		range_end, output ready);
endinterface

interface ctr_out_if;
	logic               valid;
	logic               ready;
	logic               event_valid;
	logic [63:0]        event_time;
	logic [31:0]        event_func;
	logic signed [31:0] event_line;
	logic               event_is_return;
	logic               range_ok;
	logic [47:0]        oldest_index;
	logic [47:0]        next_index;
	logic [10:0]        held_count;
	logic [31:0]        stack_entry;
	logic               stack_entry_valid;
	logic               last;

	modport source (output valid, event_valid, event_time, event_func, event_line,
		event_is_return, range_ok, oldest_index, next_index, held_count, stack_entry,
		stack_entry_valid, last, input ready);
	modport sink (input valid, event_valid, event_time, event_func, event_line,
		event_is_return, range_ok, oldest_index, next_index, held_count, stack_entry,
		stack_entry_valid, last, output ready);
endinterface

FILE: rtl/ctr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ctr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/call_trace_ring_with_stack_core.sv
// Top level: call/return trace ring with bounded call stack and deepest-stack record.
// One item is taken at a time. A call, range check, clear or unused code passes through the
// execute and output states, a return also through a return state, and an event read through
// address, wait and data states around the registered read port of the ring memory. Each
// sequence stalls while a result waits on the output. A call that deepens the recorded stack
// along a new path also copies each live stack entry that differs from the record. Take
// deepest stack streams each recorded entry, then copies the differing live stack entries.
// The capacity register should be followed by a clear.
module call_trace_ring_with_stack_core
	import ctr_pkg::*;
#(
	parameter int RING_DEPTH  = 1024,
	parameter int STACK_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	ctr_in_if.sink      in,
	ctr_out_if.source   out
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam int SW = $clog2(STACK_DEPTH);
	localparam int LW = $clog2(STACK_DEPTH + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EXEC  = 4'd1;
	localparam logic [3:0] S_RET   = 4'd2;
	localparam logic [3:0] S_RADR  = 4'd3;
	localparam logic [3:0] S_RWAIT = 4'd4;
	localparam logic [3:0] S_RDAT  = 4'd5;
	localparam logic [3:0] S_OUT   = 4'd6;
	localparam logic [3:0] S_CPY   = 4'd7;
	localparam logic [3:0] S_DRD   = 4'd8;
	localparam logic [3:0] S_DWR   = 4'd9;

	logic [3:0]  state_q;
	logic [10:0] cap_q;
	logic [47:0] wc_q;
	logic [47:0] oldest_q;
	logic [AW-1:0] ws_q;
	logic [LW-1:0] lvl_q;
	logic [LW-1:0] dlvl_q;
	logic [LW-1:0] m_q;
	logic [15:0] exc_q;
	logic [LW-1:0] k_q;
	logic [LW-1:0] cp_q;
	logic [LW-1:0] cend_q;
	logic [LW-1:0] ctgt_q;
	logic          cpv_s1;
	logic [SW-1:0] cpa_s1;
	logic          rvalid_q;
	logic          rok_q;
	logic [CW-1:0] d_q;
	logic [AW-1:0] slot_q;

	logic [2:0]         op_q;
	logic [31:0]        func_q;
	logic signed [31:0] line_q;
	logic [63:0]        time_q;
	logic [47:0]        beg_q;
	logic [47:0]        end_q;

	logic               out_valid_q;
	logic               o_event_valid_q;
	logic [63:0]        o_event_time_q;
	logic [31:0]        o_event_func_q;
	logic signed [31:0] o_event_line_q;
	logic               o_event_is_return_q;
	logic               o_range_ok_q;
	logic [47:0]        o_oldest_q;
	logic [47:0]        o_next_q;
	logic [10:0]        o_held_q;
	logic [31:0]        o_stack_entry_q;
	logic               o_stack_entry_valid_q;
	logic               o_last_q;

	logic [CW-1:0] ec;
	logic [47:0]   ec48;
	logic [47:0]   oldest_c;
	logic [47:0]   held48;
	logic          cap_on;
	logic          log_ok;
	logic          push_ok;
	logic          out_free;
	logic          out_load;
	logic          in_acc;
	logic [LW-1:0] lvl_m1;
	logic [CW-1:0] ws_ext;
	logic [CW-1:0] ws_inc;

	ring_entry_t   ring_wdata;
	ring_entry_t   ring_rdata;
	logic          ring_we;
	logic [31:0]   call_rdata;
	logic          call_we;
	logic [SW-1:0] call_raddr;
	logic [31:0]   deep_rdata;
	logic          deep_we;
	logic [SW-1:0] deep_waddr;
	logic [31:0]   deep_wdata;
	logic [31:0]   ret_f;

	logic               n_event_valid;
	logic [63:0]        n_event_time;
	logic [31:0]        n_event_func;
	logic signed [31:0] n_event_line;
	logic               n_event_is_return;
	logic               n_range_ok;
	logic [31:0]        n_stack_entry;
	logic               n_stack_entry_valid;
	logic               n_last;

	always_comb begin
		if ({21'd0, cap_q} > 32'(RING_DEPTH)) begin
			ec = CW'(RING_DEPTH);
		end else begin
			ec = CW'(cap_q);
		end
	end

	assign ec48     = 48'(ec);
	assign cap_on   = (ec != '0);
	assign oldest_c = !cap_on ? wc_q : ((wc_q > ec48) ? (wc_q - ec48) : '0);
	assign held48   = (wc_q < ec48) ? wc_q : ec48;
	assign log_ok   = cap_on && (wc_q != INDEX_MAX);
	assign push_ok  = (lvl_q < LW'(STACK_DEPTH));
	assign lvl_m1   = lvl_q - 1'b1;
	assign ws_ext   = CW'(ws_q);
	assign ws_inc   = ws_ext + 1'b1;
	assign out_free = !out_valid_q || out.ready;
	assign in.ready = (state_q == S_IDLE);
	assign in_acc   = in.valid && in.ready;
	assign ret_f    = ((exc_q == '0) && (lvl_q != '0)) ? call_rdata : '0;

	always_comb begin
		ring_wdata.t    = time_q;
		ring_wdata.line = line_q;
		if (state_q == S_RET) begin
			ring_wdata.func   = ret_f;
			ring_wdata.is_ret = 1'b1;
		end else begin
			ring_wdata.func   = func_q;
			ring_wdata.is_ret = 1'b0;
		end
		ring_we = log_ok && (((state_q == S_EXEC) && (op_q == OP_CALL)) || (state_q == S_RET));
		call_we = (state_q == S_EXEC) && (op_q == OP_CALL) && cap_on && push_ok;
		call_raddr = (state_q == S_CPY) ? cp_q[SW-1:0] : lvl_m1[SW-1:0];
		if (cpv_s1) begin
			deep_we    = 1'b1;
			deep_waddr = cpa_s1;
			deep_wdata = call_rdata;
		end else begin
			deep_we    = call_we && (lvl_q >= dlvl_q);
			deep_waddr = lvl_q[SW-1:0];
			deep_wdata = func_q;
		end
	end

	ctr_ram #(.WIDTH($bits(ring_entry_t)), .DEPTH(RING_DEPTH)) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ws_q),
		.wdata (ring_wdata),
		.raddr (slot_q),
		.rdata (ring_rdata)
	);

	ctr_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_call (
		.clk   (clk),
		.we    (call_we),
		.waddr (lvl_q[SW-1:0]),
		.wdata (func_q),
		.raddr (call_raddr),
		.rdata (call_rdata)
	);

	ctr_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_deep (
		.clk   (clk),
		.we    (deep_we),
		.waddr (deep_waddr),
		.wdata (deep_wdata),
		.raddr (k_q[SW-1:0]),
		.rdata (deep_rdata)
	);

	always_comb begin
		n_event_valid       = 1'b0;
		n_event_time        = '0;
		n_event_func        = '0;
		n_event_line        = '0;
		n_event_is_return   = 1'b0;
		n_range_ok          = 1'b0;
		n_stack_entry       = '0;
		n_stack_entry_valid = 1'b0;
		n_last              = 1'b1;
		out_load            = 1'b0;
		unique case (state_q)
			S_OUT: begin
				out_load   = out_free;
				n_range_ok = (op_q == OP_RANGE) && rok_q;
			end
			S_RDAT: begin
				out_load = out_free;
				if (rvalid_q) begin
					n_event_valid     = 1'b1;
					n_event_time      = ring_rdata.t;
					n_event_func      = ring_rdata.func;
					n_event_line      = ring_rdata.line;
					n_event_is_return = ring_rdata.is_ret;
				end
			end
			S_DWR: begin
				out_load            = out_free;
				n_stack_entry       = deep_rdata;
				n_stack_entry_valid = 1'b1;
				n_last              = (k_q + 1'b1 == dlvl_q);
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= in.operation;
			func_q <= in.func_index;
			line_q <= in.line;
			time_q <= in.time_ns;
			beg_q  <= in.range_begin;
			end_q  <= in.range_end;
		end
		if (out_load) begin
			o_event_valid_q       <= n_event_valid;
			o_event_time_q        <= n_event_time;
			o_event_func_q        <= n_event_func;
			o_event_line_q        <= n_event_line;
			o_event_is_return_q   <= n_event_is_return;
			o_range_ok_q          <= n_range_ok;
			o_oldest_q            <= oldest_c;
			o_next_q              <= wc_q;
			o_held_q              <= held48[10:0];
			o_stack_entry_q       <= n_stack_entry;
			o_stack_entry_valid_q <= n_stack_entry_valid;
			o_last_q              <= n_last;
		end
		oldest_q <= oldest_c;
		cpa_s1   <= cp_q[SW-1:0];
		if (state_q == S_EXEC) begin
			rvalid_q <= cap_on && (beg_q >= oldest_q) && (beg_q < wc_q);
			d_q      <= CW'(wc_q - beg_q);
			rok_q    <= (beg_q >= end_q) ? (beg_q == end_q)
				: ((beg_q >= oldest_q) && (end_q <= wc_q));
		end
		if (state_q == S_RADR) begin
			if (ws_ext >= d_q) begin
				slot_q <= AW'(ws_ext - d_q);
			end else begin
				slot_q <= AW'(ws_ext + ec - d_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= CAP_RESET;
			wc_q        <= '0;
			ws_q        <= '0;
			lvl_q       <= '0;
			dlvl_q      <= '0;
			m_q         <= '0;
			exc_q       <= '0;
			k_q         <= '0;
			cp_q        <= '0;
			cend_q      <= '0;
			ctgt_q      <= '0;
			cpv_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
			cpv_s1 <= (state_q == S_CPY) && (cp_q != cend_q);
			if (ring_we) begin
				wc_q <= wc_q + 1'b1;
				ws_q <= (ws_inc >= ec) ? '0 : AW'(ws_inc);
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					priority case (op_q)
						OP_CALL: begin
							state_q <= S_OUT;
							if (cap_on) begin
								if (push_ok) begin
									lvl_q <= lvl_q + 1'b1;
									if (lvl_q >= dlvl_q) begin
										if (m_q == lvl_q) begin
											dlvl_q <= lvl_q + 1'b1;
											m_q    <= lvl_q + 1'b1;
										end else begin
											cp_q    <= m_q;
											cend_q  <= lvl_q;
											ctgt_q  <= lvl_q + 1'b1;
											state_q <= S_CPY;
										end
									end
								end else if (exc_q != EXCESS_MAX) begin
									exc_q <= exc_q + 1'b1;
								end
							end
						end
						OP_RETURN: state_q <= S_RET;
						OP_READ:   state_q <= S_RADR;
						OP_TAKE: begin
							k_q <= '0;
							state_q <= (dlvl_q == '0) ? S_OUT : S_DRD;
						end
						OP_CLEAR: begin
							wc_q    <= '0;
							ws_q    <= '0;
							lvl_q   <= '0;
							exc_q   <= '0;
							dlvl_q  <= '0;
							m_q     <= '0;
							state_q <= S_OUT;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_RET: begin
					if (cap_on) begin
						if (exc_q != '0) begin
							exc_q <= exc_q - 1'b1;
						end else if (lvl_q != '0) begin
							lvl_q <= lvl_m1;
							if (m_q > lvl_m1) begin
								m_q <= lvl_m1;
							end
						end
					end
					state_q <= S_OUT;
				end
				S_RADR:  state_q <= S_RWAIT;
				S_RWAIT: state_q <= S_RDAT;
				S_RDAT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_free) begin
						if (op_q == OP_TAKE) begin
							cp_q    <= m_q;
							cend_q  <= lvl_q;
							ctgt_q  <= lvl_q;
							state_q <= S_CPY;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_CPY: begin
					if (cp_q == cend_q) begin
						dlvl_q  <= ctgt_q;
						m_q     <= ctgt_q;
						state_q <= (op_q == OP_CALL) ? S_OUT : S_IDLE;
					end else begin
						cp_q <= cp_q + 1'b1;
					end
				end
				S_DRD: state_q <= S_DWR;
				S_DWR: begin
					if (out_free) begin
						if (k_q + 1'b1 == dlvl_q) begin
							cp_q    <= m_q;
							cend_q  <= lvl_q;
							ctgt_q  <= lvl_q;
							state_q <= S_CPY;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_DRD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out.valid             = out_valid_q;
	assign out.event_valid       = o_event_valid_q;
	assign out.event_time        = o_event_time_q;
	assign out.event_func        = o_event_func_q;
	assign out.event_line        = o_event_line_q;
	assign out.event_is_return   = o_event_is_return_q;
	assign out.range_ok          = o_range_ok_q;
	assign out.oldest_index      = o_oldest_q;
	assign out.next_index        = o_next_q;
	assign out.held_count        = o_held_q;
	assign out.stack_entry       = o_stack_entry_q;
	assign out.stack_entry_valid = o_stack_entry_valid_q;
	assign out.last              = o_last_q;

endmodule

FILE: rtl/ctr_checker.sv
// Checker: port-level assertions for the call trace ring, bound to the top level.
module ctr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        event_valid,
	input logic        range_ok,
	input logic        stack_entry_valid,
	input logic [31:0] stack_entry,
	input logic        last,
	input logic [47:0] oldest_index,
	input logic [47:0] next_index,
	input logic [10:0] held_count
);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("transaction accepted while previous one in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(stack_entry) && $stable(last)
			&& $stable(next_index))
		else $error("stalled result transaction changed");

	a_window_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> oldest_index <= next_index)
		else $error("oldest index beyond next index");

	a_held_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (next_index[10:0] - oldest_index[10:0]) == held_count)
		else $error("held count disagrees with window");

	a_stack_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stack_entry_valid |-> !event_valid && !range_ok)
		else $error("stack entry mixed with event or range result");

endmodule

bind call_trace_ring_with_stack_core ctr_checker u_ctr_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in.valid),
	.in_ready          (in.ready),
	.out_valid         (out.valid),
	.out_ready         (out.ready),
	.event_valid       (out.event_valid),
	.range_ok          (out.range_ok),
	.stack_entry_valid (out.stack_entry_valid),
	.stack_entry       (out.stack_entry),
	.last              (out.last),
	.oldest_index      (out.oldest_index),
	.next_index        (out.next_index),
	.held_count        (out.held_count)
);
